/* rtl/core/hpq_pkg.sv */
`timescale 1ns / 1ps

package hpq_pkg;

   // Default sizing
   localparam int HEAP_DEPTH_DEF = 1024;
   localparam int ELEM_WIDTH_DEF = 32;

   // Operation codes
   typedef enum logic [2:0] {
      OP_PUSH  = 3'd0,
      OP_POP   = 3'd1,
      OP_CLEAR = 3'd2,
      OP_LOAD  = 3'd3,
      OP_BUILD = 3'd4
   } opcode_type;

   // Result status codes
   typedef enum logic [1:0] {
      STAT_OK    = 2'd0,
      STAT_EMPTY = 2'd1,
      STAT_FULL  = 2'd2
   } status_type;

   // Request and response words
   typedef struct packed {
      logic [2:0]         opcode;
      logic signed [31:0] value;
   } req_type;

   typedef struct packed {
      logic signed [31:0] popped;
      logic               popped_valid;
      logic [1:0]         status;
      logic [10:0]        count;
      logic               is_empty;
      logic               is_full;
   } rsp_type;

   // Microprogram steps
   typedef enum logic [4:0] {
      ST_IDLE,
      ST_PU0, ST_PU1, ST_PU2, ST_PUW,
      ST_LD0, ST_FULLS,
      ST_PO0, ST_PO1, ST_PO2, ST_EMPS,
      ST_CLR,
      ST_BL0, ST_BL1, ST_BL2,
      ST_SD0, ST_SD1, ST_SD2, ST_SD3, ST_SDW,
      ST_RESP
   } step_type;

   typedef enum logic [1:0] {
      SEQ_NEXT, SEQ_JUMP, SEQ_JCOND, SEQ_DISPATCH
   } seq_type;

   typedef enum logic [3:0] {
      C_NONE, C_FULL, C_NOT_FULL, C_EMPTY, C_IDX_ZERO, C_CNT_LT2, C_POS_ZERO,
      C_LEFT_OUT, C_RIGHT_OUT, C_ABOVE, C_CONT, C_BUILD
   } cond_type;

   // When the datapath updates of a step take effect
   typedef enum logic [1:0] {
      G_ALWAYS, G_COND, G_NCOND, G_ABOVE
   } gate_type;

   typedef enum logic [1:0] {
      CMP_TMP_RD, CMP_RD_VAL, CMP_VAL_TMP
   } cmp_type;

   typedef enum logic [2:0] {
      IDX_HOLD, IDX_CNT, IDX_PARENT, IDX_ZERO, IDX_POSM1, IDX_CHD
   } idx_op_type;

   typedef enum logic [1:0] {
      CNT_HOLD, CNT_INC, CNT_DEC, CNT_CLR
   } cnt_op_type;

   typedef enum logic [1:0] {
      POS_HOLD, POS_HALF, POS_DEC
   } pos_op_type;

   typedef enum logic [1:0] {
      CHD_HOLD, CHD_LEFT_IDX, CHD_LEFT_CHD, CHD_INC
   } chd_op_type;

   typedef enum logic {
      VAL_HOLD, VAL_RDQ
   } val_op_type;

   typedef enum logic {
      TMP_HOLD, TMP_RDQ
   } tmp_op_type;

   typedef enum logic [2:0] {
      RD_ZERO, RD_PARENT, RD_LAST, RD_POSM1, RD_LEFT_IDX, RD_LEFT_CHD, RD_RIGHT
   } rd_op_type;

   typedef enum logic [2:0] {
      WR_NONE, WR_IDX_TMP, WR_IDX_RDQ, WR_IDX_VAL, WR_CNT_TMP
   } wr_op_type;

   typedef enum logic [2:0] {
      OUT_NONE, OUT_POP, OUT_FULL, OUT_EMPTY, OUT_DONE
   } out_op_type;

   // One control word
   typedef struct packed {
      seq_type    seq;
      cond_type   cond;
      gate_type   gate;
      step_type   target;
      cmp_type    cmp;
      idx_op_type idx_op;
      cnt_op_type cnt_op;
      pos_op_type pos_op;
      chd_op_type chd_op;
      val_op_type val_op;
      tmp_op_type tmp_op;
      rd_op_type  rd_op;
      wr_op_type  wr_op;
      out_op_type out_op;
   } ucode_type;

   // Control from sequencer to datapath
   typedef struct packed {
      ucode_type uc;
      logic      upd_en;
      logic      accept;
   } ctrl_type;

   // Status flags from datapath to sequencer
   typedef struct packed {
      logic full;
      logic empty;
      logic idx_zero;
      logic cnt_lt2;
      logic pos_zero;
      logic left_out;
      logic right_out;
      logic above;
      logic cont;
      logic build;
   } flags_type;

   localparam ucode_type UC_NOP = '{
      seq: SEQ_NEXT, cond: C_NONE, gate: G_ALWAYS, target: ST_IDLE,
      cmp: CMP_TMP_RD, idx_op: IDX_HOLD, cnt_op: CNT_HOLD, pos_op: POS_HOLD,
      chd_op: CHD_HOLD, val_op: VAL_HOLD, tmp_op: TMP_HOLD, rd_op: RD_ZERO,
      wr_op: WR_NONE, out_op: OUT_NONE};

   // Control store
   function automatic ucode_type ucode_rom(step_type step);
      ucode_type w;
      w = UC_NOP;
      case (step)
         ST_IDLE: begin
            w.seq = SEQ_DISPATCH;
         end
         // push: append at the end, then walk toward the root
         ST_PU0: begin
            w.seq = SEQ_JCOND; w.cond = C_FULL; w.target = ST_FULLS;
            w.gate = G_NCOND; w.idx_op = IDX_CNT; w.cnt_op = CNT_INC;
         end
         ST_PU1: begin
            w.seq = SEQ_JCOND; w.cond = C_IDX_ZERO; w.target = ST_PUW;
            w.rd_op = RD_PARENT;
         end
         ST_PU2: begin
            w.seq = SEQ_JCOND; w.cond = C_ABOVE; w.target = ST_PU1;
            w.gate = G_COND; w.cmp = CMP_TMP_RD;
            w.wr_op = WR_IDX_RDQ; w.idx_op = IDX_PARENT;
         end
         ST_PUW: begin
            w.seq = SEQ_JUMP; w.target = ST_RESP; w.wr_op = WR_IDX_TMP;
         end
         // raw load, falls into the full report
         ST_LD0: begin
            w.seq = SEQ_JCOND; w.cond = C_NOT_FULL; w.target = ST_RESP;
            w.gate = G_COND; w.wr_op = WR_CNT_TMP; w.cnt_op = CNT_INC;
         end
         ST_FULLS: begin
            w.seq = SEQ_JUMP; w.target = ST_RESP; w.out_op = OUT_FULL;
         end
         // pop: take the root, move the last element up, sift down
         ST_PO0: begin
            w.seq = SEQ_JCOND; w.cond = C_EMPTY; w.target = ST_EMPS;
            w.rd_op = RD_ZERO;
         end
         ST_PO1: begin
            w.out_op = OUT_POP; w.cnt_op = CNT_DEC; w.rd_op = RD_LAST;
         end
         ST_PO2: begin
            w.seq = SEQ_JUMP; w.target = ST_SD0;
            w.tmp_op = TMP_RDQ; w.idx_op = IDX_ZERO;
         end
         ST_EMPS: begin
            w.seq = SEQ_JUMP; w.target = ST_RESP; w.out_op = OUT_EMPTY;
         end
         ST_CLR: begin
            w.seq = SEQ_JUMP; w.target = ST_RESP; w.cnt_op = CNT_CLR;
         end
         // build: sift down every inner node, last one first
         ST_BL0: begin
            w.seq = SEQ_JCOND; w.cond = C_CNT_LT2; w.target = ST_RESP;
            w.gate = G_NCOND; w.pos_op = POS_HALF;
         end
         ST_BL1: begin
            w.seq = SEQ_JCOND; w.cond = C_POS_ZERO; w.target = ST_RESP;
            w.gate = G_NCOND; w.pos_op = POS_DEC; w.idx_op = IDX_POSM1;
            w.rd_op = RD_POSM1;
         end
         ST_BL2: begin
            w.tmp_op = TMP_RDQ;
         end
         // sift-down routine, steps SD1 to SD3 per level; SD2 is skipped where there is no right child
         ST_SD0: begin
            w.seq = SEQ_JCOND; w.cond = C_LEFT_OUT; w.target = ST_SDW;
            w.chd_op = CHD_LEFT_IDX; w.rd_op = RD_LEFT_IDX;
         end
         ST_SD1: begin
            w.seq = SEQ_JCOND; w.cond = C_RIGHT_OUT; w.target = ST_SD3;
            w.val_op = VAL_RDQ; w.rd_op = RD_RIGHT;
         end
         ST_SD2: begin
            w.gate = G_ABOVE; w.cmp = CMP_RD_VAL;
            w.val_op = VAL_RDQ; w.chd_op = CHD_INC;
         end
         ST_SD3: begin
            w.seq = SEQ_JCOND; w.cond = C_CONT; w.target = ST_SD1;
            w.gate = G_ABOVE; w.cmp = CMP_VAL_TMP; w.wr_op = WR_IDX_VAL;
            w.idx_op = IDX_CHD; w.chd_op = CHD_LEFT_CHD; w.rd_op = RD_LEFT_CHD;
         end
         ST_SDW: begin
            w.seq = SEQ_JCOND; w.cond = C_BUILD; w.target = ST_BL1;
            w.wr_op = WR_IDX_TMP;
         end
         ST_RESP: begin
            w.seq = SEQ_JUMP; w.target = ST_IDLE; w.out_op = OUT_DONE;
         end
         default: begin
            w.seq = SEQ_JUMP; w.target = ST_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

/* rtl/core/binary_heap_priority_queue.sv */
// Run time grows with the levels a push moves up and the levels a pop or build compares;
//   unused codes, clear and load answer without a walk, as do push or load on a full
//   heap and pop on an empty one; a build sifts every inner node, a push at the root skips
//   the walk; a compare skips a step at a node with one child (one memory read per step).
// One word at a time: busy stays high until the strobe; the next word is taken in that cycle.
// Synchronous active-high reset empties the heap and sets min order; the receiver cannot stall.
`timescale 1ns / 1ps

module binary_heap_priority_queue
   import hpq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data
);

   ctrl_type  ctrl;
   flags_type flags;

   // microprogram sequencer
   hpq_seq u_seq (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .opcode (req_data.opcode),
      .flags  (flags),
      .busy   (busy),
      .ctrl   (ctrl)
   );

   // element memory and working registers
   hpq_dpath #(
      .HEAP_DEPTH (HEAP_DEPTH),
      .ELEM_WIDTH (ELEM_WIDTH)
   ) u_dpath (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_data    (req_data),
      .ctrl        (ctrl),
      .flags       (flags),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data)
   );

endmodule

/* rtl/core/hpq_seq.sv */
`timescale 1ns / 1ps

module hpq_seq
   import hpq_pkg::*;
(
   input  logic      clock,
   input  logic      reset,
   input  logic      start,
   input  logic [2:0] opcode,
   input  flags_type flags,
   output logic      busy,
   output ctrl_type  ctrl
);

   step_type  pc_ff, pc_in;
   ucode_type uc;
   logic      cond_hit;
   logic      accept;
   step_type  entry;

   assign uc     = ucode_rom(pc_ff);
   assign busy   = (pc_ff != ST_IDLE);
   assign accept = start && !busy;

   // condition select
   always_comb begin
      case (uc.cond)
         C_NONE:      cond_hit = 1'b0;
         C_FULL:      cond_hit = flags.full;
         C_NOT_FULL:  cond_hit = !flags.full;
         C_EMPTY:     cond_hit = flags.empty;
         C_IDX_ZERO:  cond_hit = flags.idx_zero;
         C_CNT_LT2:   cond_hit = flags.cnt_lt2;
         C_POS_ZERO:  cond_hit = flags.pos_zero;
         C_LEFT_OUT:  cond_hit = flags.left_out;
         C_RIGHT_OUT: cond_hit = flags.right_out;
         C_ABOVE:     cond_hit = flags.above;
         C_CONT:      cond_hit = flags.cont;
         C_BUILD:     cond_hit = flags.build;
         default:     cond_hit = 1'b0;
      endcase
   end

   // opcode entry points; unused codes just answer
   always_comb begin
      case (opcode)
         OP_PUSH:  entry = ST_PU0;
         OP_POP:   entry = ST_PO0;
         OP_CLEAR: entry = ST_CLR;
         OP_LOAD:  entry = ST_LD0;
         OP_BUILD: entry = ST_BL0;
         default:  entry = ST_RESP;
      endcase
   end

   // next step
   always_comb begin
      case (uc.seq)
         SEQ_NEXT:     pc_in = step_type'(pc_ff + 5'd1);
         SEQ_JUMP:     pc_in = uc.target;
         SEQ_JCOND:    pc_in = cond_hit ? uc.target : step_type'(pc_ff + 5'd1);
         SEQ_DISPATCH: pc_in = accept ? entry : ST_IDLE;
         default:      pc_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      ctrl.uc     = uc;
      ctrl.accept = accept;
      case (uc.gate)
         G_ALWAYS: ctrl.upd_en = 1'b1;
         G_COND:   ctrl.upd_en = cond_hit;
         G_NCOND:  ctrl.upd_en = !cond_hit;
         G_ABOVE:  ctrl.upd_en = flags.above;
         default:  ctrl.upd_en = 1'b0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pc_ff <= ST_IDLE;
      end else begin
         pc_ff <= pc_in;
      end
   end

endmodule

/* rtl/core/hpq_dpath.sv */
`timescale 1ns / 1ps

module hpq_dpath
   import hpq_pkg::*;
#(
   parameter int HEAP_DEPTH = HEAP_DEPTH_DEF,
   parameter int ELEM_WIDTH = ELEM_WIDTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      csr_wr_en,
   input  logic      csr_wr_data,
   input  req_type   req_data,
   input  ctrl_type  ctrl,
   output flags_type flags,
   output logic      rsp_valid,
   output rsp_type   rsp_data
);

   localparam int AW = $clog2(HEAP_DEPTH);
   localparam int CW = $clog2(HEAP_DEPTH + 1);
   localparam int KW = AW + 1;

   typedef logic signed [ELEM_WIDTH-1:0] elem_type;

   elem_type mem [HEAP_DEPTH];

   logic [CW-1:0] cnt_ff, cnt_in;
   logic [AW-1:0] idx_ff, idx_in;
   logic [AW-1:0] chd_ff, chd_in;
   logic [AW-1:0] pos_ff, pos_in;
   elem_type      tmp_ff, tmp_in;
   elem_type      val_ff, val_in;
   elem_type      rdq_ff;
   logic signed [31:0] popped_ff, popped_in;
   logic          pvalid_ff, pvalid_in;
   status_type    status_ff, status_in;
   logic          build_ff, build_in;
   logic          order_ff;
   logic          rsp_valid_ff, rsp_valid_in;
   rsp_type       rsp_ff, rsp_in;

   logic [AW-1:0] rd_addr;
   logic [AW-1:0] wr_addr;
   elem_type      wr_data;
   logic          wr_en;
   logic [KW-1:0] left_idx, left_chd, right_chd, limit;
   logic [AW-1:0] parent, pos_m1, last;
   elem_type      cmp_a, cmp_b;
   logic          above;
   ucode_type     uc;
   logic          upd;

   assign uc  = ctrl.uc;
   assign upd = ctrl.upd_en;

   // index arithmetic
   assign left_idx  = {idx_ff, 1'b1};
   assign left_chd  = {chd_ff, 1'b1};
   assign right_chd = KW'(chd_ff) + KW'(1);
   assign limit     = KW'(cnt_ff);
   assign parent    = AW'((idx_ff - 1'b1) >> 1);
   assign pos_m1    = pos_ff - 1'b1;
   assign last      = AW'(cnt_ff - 1'b1);

   // order compare: a belongs strictly above b
   always_comb begin
      case (uc.cmp)
         CMP_TMP_RD:  begin cmp_a = tmp_ff; cmp_b = rdq_ff; end
         CMP_RD_VAL:  begin cmp_a = rdq_ff; cmp_b = val_ff; end
         CMP_VAL_TMP: begin cmp_a = val_ff; cmp_b = tmp_ff; end
         default:     begin cmp_a = tmp_ff; cmp_b = rdq_ff; end
      endcase
      above = order_ff ? (cmp_a > cmp_b) : (cmp_a < cmp_b);
   end

   // flags to the sequencer
   always_comb begin
      flags.full      = (cnt_ff == CW'(HEAP_DEPTH));
      flags.empty     = (cnt_ff == '0);
      flags.idx_zero  = (idx_ff == '0);
      flags.cnt_lt2   = (cnt_ff < CW'(2));
      flags.pos_zero  = (pos_ff == '0);
      flags.left_out  = (left_idx >= limit);
      flags.right_out = (right_chd >= limit);
      flags.above     = above;
      flags.cont      = above && (left_chd < limit);
      flags.build     = build_ff;
   end

   // memory read address
   always_comb begin
      case (uc.rd_op)
         RD_ZERO:     rd_addr = '0;
         RD_PARENT:   rd_addr = parent;
         RD_LAST:     rd_addr = last;
         RD_POSM1:    rd_addr = pos_m1;
         RD_LEFT_IDX: rd_addr = AW'(left_idx);
         RD_LEFT_CHD: rd_addr = AW'(left_chd);
         RD_RIGHT:    rd_addr = AW'(right_chd);
         default:     rd_addr = '0;
      endcase
   end

   // memory write port
   always_comb begin
      wr_en   = upd && (uc.wr_op != WR_NONE);
      wr_addr = idx_ff;
      case (uc.wr_op)
         WR_IDX_TMP: wr_data = tmp_ff;
         WR_IDX_RDQ: wr_data = rdq_ff;
         WR_IDX_VAL: wr_data = val_ff;
         WR_CNT_TMP: begin
            wr_data = tmp_ff;
            wr_addr = AW'(cnt_ff);
         end
         default:    wr_data = tmp_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rdq_ff <= mem[rd_addr];
   end

   // working registers
   always_comb begin
      idx_in    = idx_ff;
      chd_in    = chd_ff;
      pos_in    = pos_ff;
      cnt_in    = cnt_ff;
      val_in    = val_ff;
      tmp_in    = tmp_ff;
      popped_in = popped_ff;
      pvalid_in = pvalid_ff;
      status_in = status_ff;
      build_in  = build_ff;
      if (ctrl.accept) begin
         tmp_in    = elem_type'(req_data.value);
         build_in  = (req_data.opcode == OP_BUILD);
         popped_in = '0;
         pvalid_in = 1'b0;
         status_in = STAT_OK;
      end
      if (upd) begin
         case (uc.idx_op)
            IDX_CNT:    idx_in = AW'(cnt_ff);
            IDX_PARENT: idx_in = parent;
            IDX_ZERO:   idx_in = '0;
            IDX_POSM1:  idx_in = pos_m1;
            IDX_CHD:    idx_in = chd_ff;
            default:    idx_in = idx_ff;
         endcase
         case (uc.chd_op)
            CHD_LEFT_IDX: chd_in = AW'(left_idx);
            CHD_LEFT_CHD: chd_in = AW'(left_chd);
            CHD_INC:      chd_in = AW'(right_chd);
            default:      chd_in = chd_ff;
         endcase
         case (uc.pos_op)
            POS_HALF: pos_in = AW'(cnt_ff >> 1);
            POS_DEC:  pos_in = pos_m1;
            default:  pos_in = pos_ff;
         endcase
         case (uc.cnt_op)
            CNT_INC: cnt_in = cnt_ff + 1'b1;
            CNT_DEC: cnt_in = cnt_ff - 1'b1;
            CNT_CLR: cnt_in = '0;
            default: cnt_in = cnt_ff;
         endcase
         if (uc.val_op == VAL_RDQ) begin
            val_in = rdq_ff;
         end
         if (uc.tmp_op == TMP_RDQ) begin
            tmp_in = rdq_ff;
         end
         case (uc.out_op)
            OUT_POP: begin
               popped_in = 32'(rdq_ff);
               pvalid_in = 1'b1;
            end
            OUT_FULL:  status_in = STAT_FULL;
            OUT_EMPTY: status_in = STAT_EMPTY;
            default:   ;
         endcase
      end
   end

   // response word, shown for one cycle
   always_comb begin
      rsp_valid_in        = (uc.out_op == OUT_DONE);
      rsp_in              = rsp_ff;
      if (rsp_valid_in) begin
         rsp_in.popped       = popped_ff;
         rsp_in.popped_valid = pvalid_ff;
         rsp_in.status       = status_ff;
         rsp_in.count        = 11'(cnt_ff);
         rsp_in.is_empty     = (cnt_ff == '0);
         rsp_in.is_full      = (cnt_ff == CW'(HEAP_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff       <= '0;
         order_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            order_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff    <= idx_in;
      chd_ff    <= chd_in;
      pos_ff    <= pos_in;
      val_ff    <= val_in;
      tmp_ff    <= tmp_in;
      popped_ff <= popped_in;
      pvalid_ff <= pvalid_in;
      status_ff <= status_in;
      build_ff  <= build_in;
      rsp_ff    <= rsp_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

endmodule

/* rtl/core/hpq_checker.sv */
`timescale 1ns / 1ps

module hpq_checker
   import hpq_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    start,
   input logic    busy,
   input logic    rsp_valid,
   input rsp_type rsp_data
);

   // an accepted word keeps the block busy
   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> busy)
      else $error("not busy after accept");

   // result shows when the block is ready again
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while busy");

   // no two results back to back
   a_rsp_pulse: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe longer than one cycle");

   // empty means zero count and never full
   a_empty: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.is_empty) |-> (rsp_data.count == '0 && !rsp_data.is_full))
      else $error("inconsistent empty flag");

   // a popped element only comes with ok status
   a_pop_ok: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.popped_valid) |-> (rsp_data.status == STAT_OK))
      else $error("popped element with error status");

endmodule

bind binary_heap_priority_queue hpq_checker u_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_data  (rsp_data)
);

/* verif/heap_checker.sv */
`timescale 1ns / 1ps

module heap_checker
   import hpq_pkg::*;
#(
   parameter int DEPTH = HEAP_DEPTH_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   input  logic    busy,
   input  req_type req_data,
   input  logic    rsp_valid,
   input  rsp_type rsp_data,
   input  logic    csr_wr_en,
   input  logic    csr_wr_data,
   output int      error_count,
   output int      pending
);

   // Shadow heap and mode
   logic signed [31:0] heap_mem [0:DEPTH-1];
   int                 heap_len;
   logic               max_first;
   rsp_type            expected_q [$];

   // a ranks strictly above b in the current order
   function automatic logic ranks_above(logic signed [31:0] a, logic signed [31:0] b);
      return max_first ? (a > b) : (a < b);
   endfunction

   // walk a new element toward the root
   task automatic bubble_up(input int start_pos);
      logic signed [31:0] hold;
      int                 j;
      int                 p;
      logic               done;
      hold = heap_mem[start_pos];
      j = start_pos;
      done = 1'b0;
      while (j > 0 && !done) begin
         p = (j - 1) / 2;
         if (!ranks_above(hold, heap_mem[p])) begin
            done = 1'b1;
         end else begin
            heap_mem[j] = heap_mem[p];
            j = p;
         end
      end
      heap_mem[j] = hold;
   endtask

   // sift down from pos within the first n elements
   task automatic bubble_down(input int pos, input int n);
      logic signed [31:0] hold;
      int                 i;
      int                 j;
      logic               done;
      hold = heap_mem[pos];
      i = pos;
      j = 2 * i + 1;
      done = 1'b0;
      while (j < n && !done) begin
         if (j + 1 < n && ranks_above(heap_mem[j+1], heap_mem[j])) j = j + 1;
         if (!ranks_above(heap_mem[j], hold)) begin
            done = 1'b1;
         end else begin
            heap_mem[i] = heap_mem[j];
            i = j;
            j = 2 * i + 1;
         end
      end
      heap_mem[i] = hold;
   endtask

   // apply one word to the shadow heap and form its result word
   task automatic predict_word(input req_type rq, output rsp_type rs);
      int p;
      rs = '0;
      case (rq.opcode)
         OP_PUSH, OP_LOAD: begin
            if (heap_len >= DEPTH) begin
               rs.status = STAT_FULL;
            end else begin
               heap_mem[heap_len] = rq.value;
               heap_len = heap_len + 1;
               if (rq.opcode == OP_PUSH) bubble_up(heap_len - 1);
            end
         end
         OP_POP: begin
            if (heap_len == 0) begin
               rs.status = STAT_EMPTY;
            end else begin
               rs.popped = heap_mem[0];
               rs.popped_valid = 1'b1;
               heap_len = heap_len - 1;
               heap_mem[0] = heap_mem[heap_len];
               if (heap_len > 1) bubble_down(0, heap_len);
            end
         end
         OP_CLEAR: begin
            heap_len = 0;
         end
         OP_BUILD: begin
            if (heap_len >= 2) begin
               for (p = (heap_len - 2) / 2; p >= 0; p--) bubble_down(p, heap_len);
            end
         end
         default: begin
         end
      endcase
      rs.count = heap_len[10:0];
      rs.is_empty = (heap_len == 0);
      rs.is_full = (heap_len == DEPTH);
   endtask

   // compare results, track the mode register, queue predictions
   always @(posedge clock) begin : watch
      rsp_type want;
      rsp_type got;
      if (reset) begin
         heap_len = 0;
         max_first = 1'b0;
         expected_q.delete();
      end else begin
         if (rsp_valid) begin
            got = rsp_data;
            if (expected_q.size() == 0) begin
               if (error_count < 10)
                  $display("checker: result word with none expected: %h", got);
               error_count = error_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.popped !== got.popped || want.popped_valid !== got.popped_valid ||
                   want.status !== got.status || want.count !== got.count ||
                   want.is_empty !== got.is_empty || want.is_full !== got.is_full) begin
                  if (error_count < 10)
                     $display({"checker: mismatch popped %h/%h valid %b/%b status %0d/%0d",
                               " count %0d/%0d empty %b/%b full %b/%b (expected/actual)"},
                              want.popped, got.popped, want.popped_valid, got.popped_valid,
                              want.status, got.status, want.count, got.count,
                              want.is_empty, got.is_empty, want.is_full, got.is_full);
                  error_count = error_count + 1;
               end
            end
         end
         if (csr_wr_en) max_first = csr_wr_data;
         if (start && !busy) begin
            predict_word(req_data, want);
            expected_q.push_back(want);
         end
      end
      pending = expected_q.size();
   end

endmodule

/* verif/testbench.sv */
`timescale 1ns / 1ps

module testbench;
   import hpq_pkg::*;

   localparam int          DEPTH       = HEAP_DEPTH_DEF;
   localparam int          CYCLE_LIMIT = 2000000;
   // spare opcodes, no operation
   localparam logic [2:0]  OP_RSVD5    = 3'd5;
   localparam logic [2:0]  OP_RSVD6    = 3'd6;
   localparam logic [2:0]  OP_RSVD7    = 3'd7;

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;
   logic    csr_wr_en;
   logic    csr_wr_data;
   int      error_count;
   int      pending;
   int      cycles;
   int      gap_pct;
   int      items_sent;
   int      held;

   binary_heap_priority_queue u_top (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   heap_checker #(.DEPTH(DEPTH)) u_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .error_count (error_count),
      .pending     (pending)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // watchdog
   initial cycles = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   // element values: extremes, a narrow band for ties, or anything
   function automatic logic signed [31:0] pick_value();
      case ($urandom_range(9))
         0: return 32'sh7FFFFFFF;
         1: return 32'sh80000000;
         2, 3, 4, 5: return $signed($urandom_range(15)) - 8;
         default: return $urandom;
      endcase
   endfunction

   // present one word, hold it until taken
   task automatic send_word(input logic [2:0] op, input logic signed [31:0] val);
      @(negedge clock);
      // sender idles this cycle with the phase's odds
      while (gap_pct > 0 && $urandom_range(99) < gap_pct) begin
         start <= 1'b0;
         @(negedge clock);
      end
      start <= 1'b1;
      req_data <= '{opcode: op, value: val};
      @(posedge clock);
      while (busy) @(posedge clock);
      items_sent = items_sent + 1;
      // rough occupancy, only to steer the stimulus
      case (op)
         OP_PUSH, OP_LOAD: if (held < DEPTH) held = held + 1;
         OP_POP:           if (held > 0) held = held - 1;
         OP_CLEAR:         held = 0;
         default: begin
         end
      endcase
   endtask

   // stop sending and wait for every outstanding result
   task automatic drain();
      @(negedge clock);
      start <= 1'b0;
      while (pending != 0) @(negedge clock);
   endtask

   // mode write, only with the block idle
   task automatic set_order(input logic max_mode);
      drain();
      @(negedge clock);
      csr_wr_en <= 1'b1;
      csr_wr_data <= max_mode;
      @(negedge clock);
      csr_wr_en <= 1'b0;
   endtask

   // mixed sequences: push-then-drain, load-build-drain, and loose noise
   task automatic run_phase(input int n_items);
      int stop_at;
      int kind;
      int k;
      int i;
      logic [2:0] op;
      stop_at = items_sent + n_items;
      while (items_sent < stop_at) begin
         if ($urandom_range(9) == 0) set_order(1'($urandom_range(1)));
         kind = $urandom_range(99);
         k = ($urandom_range(9) == 0) ? $urandom_range(1, 100) : $urandom_range(1, 20);
         if (kind < 40) begin
            for (i = 0; i < k; i++) send_word(OP_PUSH, pick_value());
            k = held + $urandom_range(2);
            for (i = 0; i < k; i++) send_word(OP_POP, $urandom);
         end else if (kind < 65) begin
            for (i = 0; i < k; i++) send_word(OP_LOAD, pick_value());
            send_word(OP_BUILD, $urandom);
            k = held + $urandom_range(2);
            for (i = 0; i < k; i++) send_word(OP_POP, $urandom);
         end else begin
            k = $urandom_range(1, 8);
            for (i = 0; i < k; i++) begin
               op = (held > 60) ? OP_CLEAR : 3'($urandom_range(7));
               send_word(op, pick_value());
            end
         end
      end
   endtask

   // stimulus and verdict
   initial begin : stimulus
      int i;
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      csr_wr_en = 1'b0;
      csr_wr_data = 1'b0;
      gap_pct = 0;
      items_sent = 0;
      held = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: empty pop, short builds, extremes, spare opcodes
      send_word(OP_POP, 32'sh0);
      send_word(OP_BUILD, 32'sh0);
      send_word(OP_PUSH, 32'sh7FFFFFFF);
      send_word(OP_BUILD, 32'sh0);
      send_word(OP_PUSH, 32'sh80000000);
      send_word(OP_PUSH, 32'sh0);
      send_word(OP_PUSH, -32'sh1);
      send_word(OP_PUSH, 32'sh1);
      send_word(OP_RSVD5, $urandom);
      send_word(OP_RSVD6, $urandom);
      send_word(OP_RSVD7, $urandom);
      send_word(OP_POP, 32'sh0);
      send_word(OP_POP, 32'sh0);
      // mode flipped with elements held, then rebuilt
      set_order(1'b1);
      send_word(OP_PUSH, 32'sh5);
      send_word(OP_POP, 32'sh0);
      send_word(OP_BUILD, 32'sh0);
      send_word(OP_POP, 32'sh0);
      send_word(OP_POP, 32'sh0);
      send_word(OP_POP, 32'sh0);
      send_word(OP_POP, 32'sh0);
      send_word(OP_LOAD, 32'sh10);
      send_word(OP_LOAD, -32'sh3);
      send_word(OP_LOAD, 32'sh10);
      send_word(OP_BUILD, 32'sh0);
      send_word(OP_POP, 32'sh0);
      send_word(OP_CLEAR, 32'sh0);

      // fill to capacity, then push and load on a full heap
      for (i = 0; i < DEPTH - 1; i++) send_word(OP_LOAD, pick_value());
      send_word(OP_PUSH, pick_value());
      send_word(OP_PUSH, pick_value());
      send_word(OP_LOAD, pick_value());
      send_word(OP_BUILD, 32'sh0);
      for (i = 0; i < 3; i++) send_word(OP_POP, 32'sh0);
      for (i = 0; i < 4; i++) send_word(OP_PUSH, pick_value());
      for (i = 0; i < 2; i++) send_word(OP_POP, 32'sh0);
      send_word(OP_CLEAR, 32'sh0);

      // random phases with sender idling 33%, 73%, none
      set_order(1'b0);
      gap_pct = 33;
      run_phase(250);
      set_order(1'b1);
      gap_pct = 73;
      run_phase(250);
      set_order(1'b0);
      gap_pct = 0;
      run_phase(250);

      drain();
      repeat (40) @(negedge clock);
      if (error_count == 0 && pending == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule

/* binary_heap_priority_queue.f */
rtl/core/hpq_pkg.sv
rtl/core/hpq_seq.sv
rtl/core/hpq_dpath.sv
rtl/core/binary_heap_priority_queue.sv
rtl/core/hpq_checker.sv
verif/heap_checker.sv
verif/testbench.sv
